// ===== src/three_class_strict_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-class strict priority queue
// Shared helpers; clock and reset are clk and rst_n in every user.
// ----------------------------------------------------------------------------
`ifndef THREE_CLASS_STRICT_PRIORITY_QUEUE_DEFINES_SVH
`define THREE_CLASS_STRICT_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication
`define TCPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TCPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// Types and constants shared by the three-class priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

    localparam int NUM_CLASSES     = 3;
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int VALUE_W         = 8;
    localparam int STAMP_W         = 32;
    localparam int ENTRY_W         = VALUE_W + STAMP_W;
    localparam int CNT_W           = 32;
    localparam int SUM_W           = 48;
    localparam int BOUND_W         = 9;
    localparam int LIMIT_W         = 7;
    localparam int APB_ADDR_W      = 4;
    localparam int APB_DATA_W      = 32;

    localparam logic signed [BOUND_W-1:0] LOW_BOUND_RST  = 9'sd30;
    localparam logic signed [BOUND_W-1:0] HIGH_BOUND_RST = 9'sd60;
    localparam logic [LIMIT_W-1:0]        QUEUE_LIMIT_RST = 7'd50;

    // register index, paddr[3:2]
    localparam logic [1:0] REG_LOW_BOUND   = 2'd0;
    localparam logic [1:0] REG_HIGH_BOUND  = 2'd1;
    localparam logic [1:0] REG_QUEUE_LIMIT = 2'd2;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_SERVE   = 1'b1;

    typedef enum logic [1:0] {
        CLS_LOW  = 2'd0,
        CLS_MED  = 2'd1,
        CLS_HIGH = 2'd2
    } cls_t;

    typedef enum logic [1:0] {
        STAT_QUEUED  = 2'd0,
        STAT_DROPPED = 2'd1,
        STAT_SERVED  = 2'd2,
        STAT_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic signed [BOUND_W-1:0] low_bound;
        logic signed [BOUND_W-1:0] high_bound;
        logic [LIMIT_W-1:0]        queue_limit;
    } cfg_t;

    typedef struct packed {
        cls_t enq_cls;
        logic enq_full;
        cls_t srv_cls;
        logic srv_any;
    } sel_t;

endpackage

`default_nettype wire

// ===== src/three_class_strict_priority_queue.sv =====
// ----------------------------------------------------------------------------
// three_class_strict_priority_queue
// Three FIFOs sharing one entry RAM, served in strict class priority.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_ready) carries action, packet_value, now_time.
//   An enqueue sorts the byte into low/medium/high by low_bound/high_bound
//   and appends {value, stamp} to that class FIFO, or drops it when the FIFO
//   holds min(queue_limit, QUEUE_DEPTH) entries. A serve pops the head of the
//   highest non-empty class. Every transfer in gives exactly one transfer out
//   (out_valid/out_ready) with status and the class totals after the item.
// Flow:
//   Enqueue or serve with nothing queued: holding register, then output
//   register; one per cycle while the output is free. Serve of a queued entry:
//   RAM read, holding register in S_READ, then output; in_ready low in S_READ.
// Reset:
//   FIFOs empty, counters zero, bounds 30/60, limit 50. The entry RAM is not
//   cleared; only written entries are ever read. No start-up delay.
// Stall:
//   One result sits in the output register, one more in a holding register;
//   with both full, in_ready drops until out_ready takes a transfer.
// Config (APB, pready tied high): 0x0 low_bound, 0x4 high_bound,
//   0x8 queue_limit; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module three_class_strict_priority_queue #(
    parameter int QUEUE_DEPTH = tcpq_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // APB configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [tcpq_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [tcpq_pkg::APB_DATA_W-1:0]       pwdata,
    output logic      [tcpq_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                       pready,
    // input channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  action,
    input  wire logic signed [tcpq_pkg::VALUE_W-1:0]   packet_value,
    input  wire logic [tcpq_pkg::STAMP_W-1:0]          now_time,
    // output channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic      [1:0]                            status,
    output logic signed [tcpq_pkg::VALUE_W-1:0]        out_value,
    output logic      [1:0]                            out_class,
    output logic      [tcpq_pkg::STAMP_W-1:0]          wait_ticks,
    output logic      [tcpq_pkg::CNT_W-1:0]            served_total,
    output logic      [tcpq_pkg::CNT_W-1:0]            lost_total,
    output logic      [tcpq_pkg::SUM_W-1:0]            wait_sum
);
    import tcpq_pkg::*;

`include "three_class_strict_priority_queue_defines.svh"

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = FILL_W + 1;
    localparam int RAM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(RAM_DEPTH);

    // ------------------------------------------------------------------
    // Configuration and class selection
    // ------------------------------------------------------------------
    cfg_t cfg;
    sel_t sel;

    tcpq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // per-class FIFO state and totals
    logic [NUM_CLASSES-1:0][FILL_W-1:0] fill_reg;
    logic [IDX_W-1:0]                   head_reg   [NUM_CLASSES];
    logic [CNT_W-1:0]                   lost_reg   [NUM_CLASSES];
    logic [CNT_W-1:0]                   served_reg [NUM_CLASSES];
    logic [SUM_W-1:0]                   acc_reg    [NUM_CLASSES];

    tcpq_select #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_select (
        .cfg          (cfg),
        .packet_value (packet_value),
        .fill         (fill_reg),
        .sel          (sel)
    );

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   in_xfer;
    logic   out_free;
    logic   res_move;
    logic   is_enq;
    logic   is_srv_hit;

    assign in_xfer    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign is_enq     = (action == ACT_ENQUEUE);
    assign is_srv_hit = (action == ACT_SERVE) && sel.srv_any;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = is_srv_hit ? S_READ : S_HOLD;
                end
            end
            S_READ:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    if (in_xfer)
                    begin
                        state_next = is_srv_hit ? S_READ : S_HOLD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        res_move = 1'b0;
        unique case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_READ:  in_ready = 1'b0;
            S_HOLD:
            begin
                in_ready = out_free;
                res_move = out_free;
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Entry RAM: class c owns rows c*QUEUE_DEPTH .. c*QUEUE_DEPTH+DEPTH-1
    // ------------------------------------------------------------------
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [SLOT_W-1:0]   tail_sum;
    logic [IDX_W-1:0]    tail_slot;

    function automatic logic [ADDR_W-1:0] class_base(input cls_t c);
        logic [ADDR_W-1:0] base;
        case (c)
            CLS_MED:  base = ADDR_W'(QUEUE_DEPTH);
            CLS_HIGH: base = ADDR_W'(2 * QUEUE_DEPTH);
            default:  base = '0;
        endcase
        return base;
    endfunction

    assign ram_we = in_xfer && is_enq && !sel.enq_full;
    assign ram_re = in_xfer && is_srv_hit;

    // tail = (head + fill) mod depth; the sum stays below twice the depth
    assign tail_sum  = SLOT_W'(head_reg[sel.enq_cls]) + SLOT_W'(fill_reg[sel.enq_cls]);
    assign tail_slot = (tail_sum >= SLOT_W'(QUEUE_DEPTH))
                     ? IDX_W'(tail_sum - SLOT_W'(QUEUE_DEPTH))
                     : IDX_W'(tail_sum);

    assign ram_waddr = class_base(sel.enq_cls) + ADDR_W'(tail_slot);
    assign ram_raddr = class_base(sel.srv_cls) + ADDR_W'(head_reg[sel.srv_cls]);

    tcpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({packet_value, now_time}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Per-class state updates
    // ------------------------------------------------------------------
    cls_t                srv_cls_reg;
    logic [STAMP_W-1:0]  now_reg;
    logic [STAMP_W-1:0]  rd_wait;
    logic [SUM_W-1:0]    acc_next;

    assign rd_wait  = now_reg - ram_rdata[STAMP_W-1:0];
    assign acc_next = acc_reg[srv_cls_reg] + SUM_W'(rd_wait);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                fill_reg[c]   <= '0;
                head_reg[c]   <= '0;
                lost_reg[c]   <= '0;
                served_reg[c] <= '0;
                acc_reg[c]    <= '0;
            end
        end
        else
        begin
            if (in_xfer && is_enq)
            begin
                if (sel.enq_full)
                begin
                    lost_reg[sel.enq_cls] <= lost_reg[sel.enq_cls] + CNT_W'(1);
                end
                else
                begin
                    fill_reg[sel.enq_cls] <= fill_reg[sel.enq_cls] + FILL_W'(1);
                end
            end
            if (ram_re)
            begin
                fill_reg[sel.srv_cls]   <= fill_reg[sel.srv_cls] - FILL_W'(1);
                served_reg[sel.srv_cls] <= served_reg[sel.srv_cls] + CNT_W'(1);
                head_reg[sel.srv_cls]   <=
                    (head_reg[sel.srv_cls] == IDX_W'(QUEUE_DEPTH - 1))
                    ? '0 : head_reg[sel.srv_cls] + IDX_W'(1);
            end
            if (state_reg == S_READ)
            begin
                acc_reg[srv_cls_reg] <= acc_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result holding register and output register
    // ------------------------------------------------------------------
    status_t             res_status;
    logic [VALUE_W-1:0]  res_value;
    cls_t                res_class;
    logic [STAMP_W-1:0]  res_wait;
    logic [CNT_W-1:0]    res_served;
    logic [CNT_W-1:0]    res_lost;
    logic [SUM_W-1:0]    res_sum;

    status_t             out_status_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    cls_t                out_class_reg;
    logic [STAMP_W-1:0]  out_wait_reg;
    logic [CNT_W-1:0]    out_served_reg;
    logic [CNT_W-1:0]    out_lost_reg;
    logic [SUM_W-1:0]    out_sum_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            srv_cls_reg <= sel.srv_cls;
            now_reg     <= now_time;
            res_value   <= '0;
            res_wait    <= '0;
            if (is_enq)
            begin
                res_class  <= sel.enq_cls;
                res_served <= served_reg[sel.enq_cls];
                res_sum    <= acc_reg[sel.enq_cls];
                if (sel.enq_full)
                begin
                    res_status <= STAT_DROPPED;
                    res_lost   <= lost_reg[sel.enq_cls] + CNT_W'(1);
                end
                else
                begin
                    res_status <= STAT_QUEUED;
                    res_lost   <= lost_reg[sel.enq_cls];
                end
            end
            else
            begin
                // serve with nothing queued; a hit is finished in S_READ
                res_status <= STAT_EMPTY;
                res_class  <= CLS_LOW;
                res_served <= '0;
                res_lost   <= '0;
                res_sum    <= '0;
            end
        end
        else if (state_reg == S_READ)
        begin
            res_status <= STAT_SERVED;
            res_value  <= ram_rdata[ENTRY_W-1:STAMP_W];
            res_class  <= srv_cls_reg;
            res_wait   <= rd_wait;
            res_served <= served_reg[srv_cls_reg];
            res_lost   <= lost_reg[srv_cls_reg];
            res_sum    <= acc_next;
        end

        if (res_move)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
            out_class_reg  <= res_class;
            out_wait_reg   <= res_wait;
            out_served_reg <= res_served;
            out_lost_reg   <= res_lost;
            out_sum_reg    <= res_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_value    = $signed(out_value_reg);
    assign out_class    = out_class_reg;
    assign wait_ticks   = out_wait_reg;
    assign served_total = out_served_reg;
    assign lost_total   = out_lost_reg;
    assign wait_sum     = out_sum_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TCPQ_ASSERT_NOW(a_ram_no_rw_overlap, ram_we, !ram_re,
        "entry RAM written and read in the same cycle")

    `TCPQ_ASSERT_NEXT(a_serve_hit_reads, ram_re, state_reg == S_READ,
        "serve with a queued entry did not wait for RAM data")

    `TCPQ_ASSERT_NOW(a_fill_in_range, 1'b1,
        (fill_reg[CLS_LOW] <= FILL_W'(QUEUE_DEPTH)) &&
        (fill_reg[CLS_MED] <= FILL_W'(QUEUE_DEPTH)) &&
        (fill_reg[CLS_HIGH] <= FILL_W'(QUEUE_DEPTH)),
        "class fill count above queue depth")

    `TCPQ_ASSERT_NEXT(a_result_lands, res_move, out_valid_reg,
        "held result not moved to output register")

endmodule

`default_nettype wire

// ===== src/tcpq_ram.sv =====
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ram #(
    parameter int WIDTH  = tcpq_pkg::ENTRY_W,
    parameter int DEPTH  = tcpq_pkg::NUM_CLASSES * tcpq_pkg::DEF_QUEUE_DEPTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/tcpq_cfg.sv =====
// ----------------------------------------------------------------------------
// tcpq_cfg
// APB register file: class bounds and per-class queue limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tcpq_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [tcpq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [tcpq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output tcpq_pkg::cfg_t                           cfg
);
    import tcpq_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_bound   <= LOW_BOUND_RST;
            cfg_reg.high_bound  <= HIGH_BOUND_RST;
            cfg_reg.queue_limit <= QUEUE_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_LOW_BOUND:   cfg_reg.low_bound   <= $signed(pwdata[BOUND_W-1:0]);
                REG_HIGH_BOUND:  cfg_reg.high_bound  <= $signed(pwdata[BOUND_W-1:0]);
                REG_QUEUE_LIMIT: cfg_reg.queue_limit <= pwdata[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LOW_BOUND:
                prdata = {{(APB_DATA_W-BOUND_W){1'b0}}, cfg_reg.low_bound};
            REG_HIGH_BOUND:
                prdata = {{(APB_DATA_W-BOUND_W){1'b0}}, cfg_reg.high_bound};
            REG_QUEUE_LIMIT:
                prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, cfg_reg.queue_limit};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/tcpq_select.sv =====
// ----------------------------------------------------------------------------
// tcpq_select
// Class decision for enqueue (bounds, capacity) and serve (highest non-empty).
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_select #(
    parameter int QUEUE_DEPTH = tcpq_pkg::DEF_QUEUE_DEPTH,
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire tcpq_pkg::cfg_t                                      cfg,
    input  wire logic signed [tcpq_pkg::VALUE_W-1:0]                 packet_value,
    input  wire logic [tcpq_pkg::NUM_CLASSES-1:0][FILL_W-1:0]        fill,
    output tcpq_pkg::sel_t                                           sel
);
    import tcpq_pkg::*;

    localparam int CMP_W = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

    logic signed [BOUND_W-1:0] value_ext;
    logic [CMP_W-1:0]          limit_ext;
    logic [CMP_W-1:0]          depth_c;
    logic [CMP_W-1:0]          cap;
    cls_t                      enq_cls;

    assign value_ext = {packet_value[VALUE_W-1], packet_value};
    assign limit_ext = CMP_W'(cfg.queue_limit);
    assign depth_c   = CMP_W'(QUEUE_DEPTH);
    assign cap       = (limit_ext < depth_c) ? limit_ext : depth_c;

    always_comb
    begin
        if (value_ext < cfg.low_bound)
        begin
            enq_cls = CLS_LOW;
        end
        else if (value_ext < cfg.high_bound)
        begin
            enq_cls = CLS_MED;
        end
        else
        begin
            enq_cls = CLS_HIGH;
        end
    end

    always_comb
    begin
        sel.enq_cls  = enq_cls;
        sel.enq_full = CMP_W'(fill[enq_cls]) >= cap;
        sel.srv_any  = 1'b1;
        if (fill[CLS_HIGH] != '0)
        begin
            sel.srv_cls = CLS_HIGH;
        end
        else if (fill[CLS_MED] != '0)
        begin
            sel.srv_cls = CLS_MED;
        end
        else if (fill[CLS_LOW] != '0)
        begin
            sel.srv_cls = CLS_LOW;
        end
        else
        begin
            sel.srv_cls = CLS_LOW;
            sel.srv_any = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb - three-class strict priority queue testbench
// Drives enqueue and serve transfers under random idling, writes the class
// bounds and queue limit over APB between phases, and checks each result
// against an in-bench copy of the three class FIFOs and their totals.
// ----------------------------------------------------------------------------
module tb;

    import tcpq_pkg::*;

    localparam int QDEPTH      = DEF_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    // one packet operation as offered on the input channel
    typedef struct {
        logic                      act;
        logic signed [VALUE_W-1:0] value;
        logic [STAMP_W-1:0]        stamp;
        bit                        drain_first;  // wait for all results before offering
    } packet_op_t;

    // one result as expected on the output channel
    typedef struct {
        status_t                   st;
        logic signed [VALUE_W-1:0] value;
        cls_t                      cls;
        logic [STAMP_W-1:0]        waited;
        logic [CNT_W-1:0]          served;
        logic [CNT_W-1:0]          lost;
        logic [SUM_W-1:0]          wsum;
    } queue_outcome_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs; everything starts at a known value
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr   = '0;
    logic [APB_DATA_W-1:0]     pwdata  = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    logic                      in_valid     = 1'b0;
    logic                      in_ready;
    logic                      action       = ACT_ENQUEUE;
    logic signed [VALUE_W-1:0] packet_value = '0;
    logic [STAMP_W-1:0]        now_time     = '0;

    logic                      out_valid;
    logic                      out_ready    = 1'b0;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] out_value;
    logic [1:0]                out_class;
    logic [STAMP_W-1:0]        wait_ticks;
    logic [CNT_W-1:0]          served_total;
    logic [CNT_W-1:0]          lost_total;
    logic [SUM_W-1:0]          wait_sum;

    three_class_strict_priority_queue uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .packet_value (packet_value),
        .now_time     (now_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_value    (out_value),
        .out_class    (out_class),
        .wait_ticks   (wait_ticks),
        .served_total (served_total),
        .lost_total   (lost_total),
        .wait_sum     (wait_sum)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    packet_op_t     packets_to_send[$];    // filled by the stimulus, drained by driver
    queue_outcome_t awaited_outcomes[$];   // predicted results, oldest first

    int  ops_queued  = 0;    // pushed by the stimulus
    int  ops_sent    = 0;    // accepted by the block
    int  bad_results = 0;    // mismatches plus results nobody asked for
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  hold_req    = 0;    // bump to request one long receiver hold-off
    int  hold_seen   = 0;
    int  hold_left   = 0;
    int  cycle_count = 0;
    logic in_took    = 1'b0; // an input transfer happened at the last rising edge
    logic [STAMP_W-1:0] tick = '0;

    // Predicted block state: three circular FIFOs plus per-class totals.
    logic signed [BOUND_W-1:0] cfg_low   = LOW_BOUND_RST;
    logic signed [BOUND_W-1:0] cfg_high  = HIGH_BOUND_RST;
    logic [LIMIT_W-1:0]        cfg_limit = QUEUE_LIMIT_RST;

    logic [VALUE_W-1:0] q_val   [NUM_CLASSES][QDEPTH];
    logic [STAMP_W-1:0] q_stamp [NUM_CLASSES][QDEPTH];
    int                 q_head  [NUM_CLASSES];
    int                 q_fill  [NUM_CLASSES];
    logic [CNT_W-1:0]   q_served[NUM_CLASSES];
    logic [CNT_W-1:0]   q_lost  [NUM_CLASSES];
    logic [SUM_W-1:0]   q_wsum  [NUM_CLASSES];

    // ------------------------------------------------------------------------
    // Predictor: apply one operation to the FIFO copy, return its result.
    // Enqueue sorts by signed compare against the 9-bit bounds; a class at
    // min(limit, depth) entries drops and bumps its loss count. Serve pops
    // the head of the highest non-empty class; an empty block returns all
    // zeros with the empty status.
    // ------------------------------------------------------------------------
    function automatic queue_outcome_t predict_outcome(input packet_op_t op);
        queue_outcome_t r;
        int  cap;
        int  c;
        int  k;
        int  slot;
        bit  found;
        r.st     = STAT_EMPTY;
        r.value  = '0;
        r.cls    = CLS_LOW;
        r.waited = '0;
        r.served = '0;
        r.lost   = '0;
        r.wsum   = '0;
        c        = CLS_LOW;
        found    = 1'b0;
        cap = (int'(cfg_limit) < QDEPTH) ? int'(cfg_limit) : QDEPTH;
        if (op.act == ACT_ENQUEUE)
        begin
            if (op.value < cfg_low)
                c = CLS_LOW;
            else if (op.value < cfg_high)
                c = CLS_MED;
            else
                c = CLS_HIGH;
            if (q_fill[c] >= cap)
            begin
                q_lost[c] = q_lost[c] + 1'b1;
                r.st = STAT_DROPPED;
            end
            else
            begin
                slot = (q_head[c] + q_fill[c]) % QDEPTH;
                q_val[c][slot]   = op.value;
                q_stamp[c][slot] = op.stamp;
                q_fill[c]++;
                r.st = STAT_QUEUED;
            end
            found = 1'b1;
        end
        else
        begin
            for (k = NUM_CLASSES - 1; k >= 0; k--)
            begin
                if (!found && q_fill[k] != 0)
                begin
                    found     = 1'b1;
                    c         = k;
                    r.value   = q_val[k][q_head[k]];
                    r.waited  = op.stamp - q_stamp[k][q_head[k]];
                    q_head[k] = (q_head[k] + 1) % QDEPTH;
                    q_fill[k]--;
                    q_served[k] = q_served[k] + 1'b1;
                    q_wsum[k]   = q_wsum[k] + r.waited;
                    r.st        = STAT_SERVED;
                end
            end
        end
        if (found)
        begin
            r.cls    = cls_t'(c);
            r.served = q_served[c];
            r.lost   = q_lost[c];
            r.wsum   = q_wsum[c];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: a new item goes out at the falling edge once the previous one
    // is taken. Payload only changes when valid is low or was just accepted.
    // An item marked drain_first waits until every result is back.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        packet_op_t op;
        if (rst_n && (!in_valid || in_took))
        begin
            if (packets_to_send.size() != 0 &&
                (!packets_to_send[0].drain_first ||
                 (!in_valid && awaited_outcomes.size() == 0)) &&
                $urandom_range(0, 99) >= tx_idle_pct)
            begin
                op = packets_to_send.pop_front();
                in_valid     <= 1'b1;
                action       <= op.act;
                packet_value <= op.value;
                now_time     <= op.stamp;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus the long hold-off while requested.
    always @(negedge clk)
    begin
        out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Long hold-off counter, in its own process so the sender keeps going.
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check the output transfer against the oldest prediction first,
    // then predict for the input transfer of the same edge. A same-edge
    // output can never belong to a same-edge input.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        packet_op_t     op;
        queue_outcome_t want;
        if (rst_n)
        begin
            in_took <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected result: status %0d class %0d value %0d",
                                 status, out_class, out_value);
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (status !== want.st || out_value !== want.value ||
                        out_class !== want.cls || wait_ticks !== want.waited ||
                        served_total !== want.served || lost_total !== want.lost ||
                        wait_sum !== want.wsum)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display({"mismatch: expected st %0d val %0d cls %0d wait %0d",
                                      " srv %0d lost %0d sum %0d; got st %0d val %0d",
                                      " cls %0d wait %0d srv %0d lost %0d sum %0d"},
                                     want.st, want.value, want.cls, want.waited,
                                     want.served, want.lost, want.wsum,
                                     status, out_value, out_class, wait_ticks,
                                     served_total, lost_total, wait_sum);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                op.act         = action;
                op.value       = packet_value;
                op.stamp       = now_time;
                op.drain_first = 1'b0;
                awaited_outcomes.push_back(predict_outcome(op));
                ops_sent++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Queue one operation stamped with the running tick. The tick mostly
    // creeps forward but now and then jumps anywhere, so waits also wrap.
    task automatic push_op(input logic act, input logic signed [VALUE_W-1:0] v,
                           input bit drain);
        packet_op_t op;
        op.act         = act;
        op.value       = v;
        op.stamp       = tick;
        op.drain_first = drain;
        packets_to_send.push_back(op);
        ops_queued++;
        if ($urandom_range(0, 39) == 0)
            tick = $urandom();
        else
            tick = tick + $urandom_range(0, 4);
    endtask

    // APB write: setup cycle, access cycle, idle. The predictor copy follows.
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LOW_BOUND:   cfg_low   = data[BOUND_W-1:0];
            REG_HIGH_BOUND:  cfg_high  = data[BOUND_W-1:0];
            REG_QUEUE_LIMIT: cfg_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input int low, input int high, input int limit);
        write_reg(REG_LOW_BOUND, low);
        write_reg(REG_HIGH_BOUND, high);
        write_reg(REG_QUEUE_LIMIT, limit);
    endtask

    // Wait until every queued item is in and every result is out, then let
    // the serve path settle before touching the registers.
    task automatic settle();
        while (ops_sent != ops_queued || awaited_outcomes.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Bursts with a common base value, so one class tends to fill up and
    // drop, and unless fill_only, serve-heavy bursts that drain it again. One item in
    // the middle of every phase (and a few at random) waits for a full drain.
    task automatic random_traffic(input int n, input bit fill_only);
        int  i;
        int  len;
        int  mode;
        int  enq_pct;
        logic signed [VALUE_W-1:0] base;
        logic signed [VALUE_W-1:0] v;
        i = 0;
        while (i < n)
        begin
            mode    = $urandom_range(0, 9);
            len     = $urandom_range(1, 40);
            base    = VALUE_W'($urandom_range(0, 255));
            enq_pct = fill_only ? 100 : (mode < 4) ? 90 : (mode < 7) ? 20 : 50;
            repeat (len)
            begin
                if (i < n)
                begin
                    if ($urandom_range(0, 3) == 0)
                        v = VALUE_W'($urandom_range(0, 255));
                    else
                        v = base + VALUE_W'($urandom_range(0, 6)) - VALUE_W'(3);
                    push_op(($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_SERVE, v,
                            (i == n / 2) || ($urandom_range(0, 199) == 0));
                    i++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int c;
        int s;
        for (c = 0; c < NUM_CLASSES; c++)
        begin
            q_head[c]   = 0;
            q_fill[c]   = 0;
            q_served[c] = '0;
            q_lost[c]   = '0;
            q_wsum[c]   = '0;
            for (s = 0; s < QDEPTH; s++)
            begin
                q_val[c][s]   = '0;
                q_stamp[c][s] = '0;
            end
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset settings (30 / 60 / 50).
        tx_idle_pct = 7;
        rx_idle_pct = 66;
        push_op(ACT_SERVE, 8'sd0, 1'b0);            // nothing to serve
        tick = 32'hFFFF_FFF0;                       // stamps just before wrap
        push_op(ACT_ENQUEUE, -8'sd128, 1'b0);       // lowest value, low class
        push_op(ACT_ENQUEUE, 8'sd127, 1'b0);        // highest value, high class
        push_op(ACT_ENQUEUE, 8'sd30, 1'b0);         // exactly low bound: medium
        push_op(ACT_ENQUEUE, 8'sd29, 1'b0);         // just under: low
        push_op(ACT_ENQUEUE, 8'sd59, 1'b0);         // just under high bound: medium
        push_op(ACT_ENQUEUE, 8'sd60, 1'b0);         // exactly high bound: high
        push_op(ACT_ENQUEUE, 8'sd0, 1'b0);
        tick = 32'd5;                               // serves after the wrap
        repeat (7) push_op(ACT_SERVE, -8'sd1, 1'b0); // high first, then medium, low
        push_op(ACT_SERVE, 8'sd0, 1'b0);            // empty again
        settle();

        // Defaults written explicitly; the receiver goes deaf for a while so
        // the block fills and stalls its input.
        load_config(30, 60, 50);
        hold_req++;
        random_traffic(150, 1'b0);
        settle();

        // Widest bounds: nothing is low, everything medium.
        load_config(-128, 128, 64);
        random_traffic(100, 1'b0);
        settle();

        // Crossed bounds: medium class starves; tight limit.
        load_config(60, 30, 5);
        random_traffic(100, 1'b0);
        settle();

        tx_idle_pct = 66;
        rx_idle_pct = 7;

        // Register extremes, limit above depth; fill medium past capacity.
        load_config(-256, 255, 127);
        random_traffic(120, 1'b1);
        settle();

        // Zero limit: every enqueue dropped, stored entries still served.
        load_config(0, 0, 0);
        random_traffic(40, 1'b0);
        settle();

        load_config(0, 0, 1);
        random_traffic(80, 1'b0);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;

        // Fill, then lower the limit below the fill level.
        load_config(20, 40, 64);
        random_traffic(60, 1'b1);
        settle();
        load_config(20, 40, 2);
        random_traffic(80, 1'b0);
        settle();

        load_config(30, 60, 50);
        random_traffic(100, 1'b0);
        settle();

        if (bad_results == 0 && awaited_outcomes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== three_class_strict_priority_queue.f =====
+incdir+src
src/tcpq_pkg.sv
src/tcpq_ram.sv
src/tcpq_cfg.sv
src/tcpq_select.sv
src/three_class_strict_priority_queue.sv
tb/tb.sv
